// ===== src/bsst_pkg.sv =====
package bsst_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned TableLenW = 11;
  localparam int unsigned IndexW    = 10;
  localparam int unsigned ValueW    = 32;

  // Operation codes carried by an input word.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // load the search bounds and key, issue the first probe
    logic step;      // take the next probe's bounds
    logic mem_we;    // write one table entry
    logic save_hit;  // keep the compare outcome for a delayed result
    logic load_out;  // load the result register
    logic out_live;  // result comes from the compare in this cycle
  } bsst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;  // no entries in use
    logic hit;       // probed entry equals the key
    logic ended;     // bounds have crossed, the key is absent
  } bsst_status_t;

endpackage

// ===== src/bsst_datapath.sv =====
module bsst_datapath
  import bsst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [TableLenW-1:0]     cfg_table_length,
  input  logic [IndexW-1:0]        in_entry_index,
  input  logic signed [ValueW-1:0] in_value,
  input  bsst_cmd_t                cmd,
  output bsst_status_t             status,
  output logic                     out_found,
  output logic [IndexW-1:0]        out_position
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Bounds are signed and must hold the depth itself, the length and minus one.
  localparam int unsigned BW0 = (AW + 1 > TableLenW) ? AW + 1 : TableLenW;
  localparam int unsigned SW  = BW0 + 1;

  logic [TableLenW-1:0]     table_length_r;
  logic [ValueW-1:0]        mem [TABLE_DEPTH];
  logic [ValueW-1:0]        rd_data_r;
  logic [ValueW-1:0]        key_r;
  logic signed [SW-1:0]     lo_r;
  logic signed [SW-1:0]     hi_r;
  logic [AW-1:0]            mid_r;
  logic                     hit_r;
  logic                     out_found_r;
  logic [IndexW-1:0]        out_position_r;

  logic [SW-1:0]            len_ext;
  logic [SW-1:0]            len_cap;
  logic [SW-1:0]            hi_start;
  logic [AW-1:0]            mid_start;
  logic signed [SW-1:0]     mid_ext;
  logic                     cmp_eq;
  logic                     cmp_below;
  logic signed [SW-1:0]     lo_nxt;
  logic signed [SW-1:0]     hi_nxt;
  logic [SW-1:0]            bound_sum;
  logic [AW-1:0]            mid_nxt;
  logic [AW-1:0]            rd_addr;
  logic                     wr_in_range;
  logic                     res_found;

  // Length register; it must be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_we) begin
      table_length_r <= cfg_table_length;
    end
  end

  // Length in use, saturated to the table depth.
  always_comb begin
    len_ext   = SW'(table_length_r);
    len_cap   = (len_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : len_ext;
    hi_start  = len_cap - SW'(1);
    mid_start = AW'(hi_start >> 1);
  end

  // Probe compare and the next pair of bounds.
  always_comb begin
    mid_ext   = SW'(mid_r);
    cmp_eq    = (rd_data_r == key_r);
    cmp_below = ($signed(rd_data_r) < $signed(key_r));
    lo_nxt    = cmp_below ? (mid_ext + SW'(1)) : lo_r;
    hi_nxt    = cmp_below ? hi_r : (mid_ext - SW'(1));
    bound_sum = SW'(lo_nxt) + SW'(hi_nxt);
    mid_nxt   = AW'(bound_sum >> 1);
    rd_addr   = cmd.start ? mid_start : mid_nxt;
  end

  assign status.len_zero = (table_length_r == '0);
  assign status.hit      = cmp_eq;
  assign status.ended    = (lo_nxt > hi_nxt);

  // Table memory: one write port, one registered read port.
  assign wr_in_range = (SW'(in_entry_index) < SW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.mem_we && wr_in_range) begin
      mem[AW'(in_entry_index)] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Search bounds and key.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r  <= '0;
      hi_r  <= hi_start;
      mid_r <= mid_start;
      key_r <= in_value;
      hit_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
        mid_r <= mid_nxt;
      end
      if (cmd.save_hit) begin
        hit_r <= cmp_eq;
      end
    end
  end

  // Result register; position is zero when nothing matched.
  assign res_found = cmd.out_live ? cmp_eq : hit_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r    <= res_found;
      out_position_r <= res_found ? IndexW'(mid_r) : '0;
    end
  end

  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

// ===== src/bsst_ctrl.sv =====
module bsst_ctrl
  import bsst_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_operation,
  input  logic         out_ready,
  input  bsst_status_t status,
  output logic         in_ready,
  output logic         out_valid,
  output bsst_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COMPARE = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequencing of writes and probes.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_WRITE) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = status.len_zero ? ST_DONE : ST_COMPARE;
          end
        end
      end
      ST_COMPARE: begin
        if (status.hit || status.ended) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.out_live = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.save_hit = 1'b1;
            state_nxt    = ST_DONE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result word stays valid until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/binary_search_sorted_table_unit.sv =====
// A write word never holds off the next word. A search probes the table once
// per cycle, at most floor(log2(TABLE_DEPTH))+1 times (11 at a depth of 1024);
// its result is valid in the cycle after the last probe, when the next word
// can be taken, or later while an earlier result is not taken.
// Reset clears the length register and the control state; table contents stay
// undefined until written.
module binary_search_sorted_table_unit
  import bsst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [IndexW-1:0]        in_entry_index,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [IndexW-1:0]        out_position,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TableLenW-1:0]     cfg_table_length
);

  bsst_cmd_t    cmd;
  bsst_status_t status;

  // The length register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  bsst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_ready    (out_ready),
    .status       (status),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  bsst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_table_length (cfg_table_length),
    .in_entry_index   (in_entry_index),
    .in_value         (in_value),
    .cmd              (cmd),
    .status           (status),
    .out_found        (out_found),
    .out_position     (out_position)
  );

  // A search holds off the next word in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_SEARCH)) |=> !in_ready)
    else $error("input taken while a search is in progress");

  // A miss reports position zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss with non-zero position");

  // A table write never raises a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_WRITE) && !out_valid) |=> !out_valid)
    else $error("result raised by a table write");

endmodule

// ===== dv/bsst_tb_pkg.sv =====
package bsst_tb_pkg;
  import bsst_pkg::*;

  localparam int TableDepth = 1024;

  // One predicted search outcome, with its key kept for messages.
  typedef struct packed {
    logic [ValueW-1:0] key;
    logic              found;
    logic [IndexW-1:0] position;
  } lookup_t;

  class search_scoreboard;
    logic signed [ValueW-1:0] table_mirror [TableDepth];
    logic [TableLenW-1:0]     length_reg = '0;
    lookup_t                  awaiting [$];
    int mismatches = 0;
    int searches   = 0;
    int hits       = 0;
    int writes     = 0;

    // Binary search over the mirrored table with the block's probe rule.
    function lookup_t search_table(logic signed [ValueW-1:0] key);
      lookup_t res;
      int lo;
      int hi;
      int mid;
      res.key      = key;
      res.found    = 1'b0;
      res.position = '0;
      lo = 0;
      hi = int'(length_reg);
      // A length beyond the table depth saturates at the depth.
      if (hi > TableDepth) hi = TableDepth;
      hi = hi - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (table_mirror[mid] == key) begin
          res.found    = 1'b1;
          res.position = IndexW'(mid);
          break;
        end
        if (table_mirror[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
      return res;
    endfunction

    // An accepted input word either updates the table or queues a prediction.
    function void note_word(logic op, logic [IndexW-1:0] idx, logic signed [ValueW-1:0] value);
      lookup_t res;
      if (op == OP_WRITE) begin
        if (idx < TableDepth) table_mirror[idx] = value;
        writes++;
      end else begin
        res = search_table(value);
        awaiting.push_back(res);
        searches++;
        if (res.found) hits++;
      end
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", what);
    endtask

    // Compare one accepted result word with the oldest prediction.
    task check_result(logic found, logic [IndexW-1:0] position);
      lookup_t want;
      if (awaiting.size() == 0) begin
        report($sformatf("result with nothing outstanding: found=%0b position=%0d",
                         found, position));
        return;
      end
      want = awaiting.pop_front();
      if (found !== want.found)
        report($sformatf("key %0d: found=%0b, predicted %0b",
                         $signed(want.key), found, want.found));
      if (position !== want.position)
        report($sformatf("key %0d: position=%0d, predicted %0d",
                         $signed(want.key), position, want.position));
    endtask

    // Predictions that never got a result count as failures and are dropped.
    task flush_missing();
      if (awaiting.size() != 0) begin
        report($sformatf("%0d predicted results never arrived", awaiting.size()));
        awaiting.delete();
      end
    endtask
  endclass

endpackage

// ===== dv/tb_binary_search_sorted_table_unit.sv =====
module tb_binary_search_sorted_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bsst_pkg::*;
  import bsst_tb_pkg::*;

  localparam logic signed [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] MaxValue = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [TableLenW-1:0]     LongestLen = {TableLenW{1'b1}};

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_operation;
  logic [IndexW-1:0]        in_entry_index;
  logic signed [ValueW-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_found;
  logic [IndexW-1:0]        out_position;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [TableLenW-1:0]     cfg_table_length;

  search_scoreboard sb = new();

  bit quiet;
  int rx_hold_len;
  int settings_made;
  int shortest_len;
  int longest_len;
  int random_items;

  binary_search_sorted_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_position     (out_position),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_length (cfg_table_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Offer one input word after a random gap and note it once accepted.
  task automatic send_word(input logic op, input logic [IndexW-1:0] idx,
                           input logic signed [ValueW-1:0] value);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_index <= idx;
    in_value       <= value;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_word(op, idx, value);
  endtask

  // The index field is ignored for searches, so it carries noise.
  task automatic search_key(input logic signed [ValueW-1:0] key);
    send_word(OP_SEARCH, IndexW'($urandom), key);
  endtask

  task automatic write_length(input logic [TableLenW-1:0] len);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_table_length <= len;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.length_reg = len;
    settings_made++;
    if (int'(len) < shortest_len) shortest_len = int'(len);
    if (int'(len) > longest_len) longest_len = int'(len);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering words and wait for every predicted result, then let a
  // trailing write finish before anything else happens.
  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 3000) begin
      @(posedge clk);
      waited++;
    end
    sb.flush_missing();
    repeat (4) @(posedge clk);
  endtask

  // Write count ascending entries from index first, spanning floor_v to
  // ceil_v; the top is clamped, so repeated entries appear now and then.
  task automatic lay_sorted(input int first, input int count,
                            input longint floor_v, input longint ceil_v);
    longint v;
    longint stride;
    int i;
    v = floor_v;
    stride = 2 * (ceil_v - floor_v) / count;
    if (stride > longint'(32'hFFFF_FFFF)) stride = longint'(32'hFFFF_FFFF);
    for (i = 0; i < count; i++) begin
      if (i == count - 1) v = ceil_v;
      send_word(OP_WRITE, IndexW'(first + i), ValueW'(v));
      v = v + $urandom_range(0, 32'(stride));
      if (v > ceil_v) v = ceil_v;
    end
  endtask

  // The result side stalls at random, and for one long stretch on request.
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_result(out_found, out_position);
    end
  end

  initial begin : stimulus
    int phase;
    int burst;
    int n;
    int pick;
    int idx;
    int span;
    logic [TableLenW-1:0] len;
    longint floor_v;
    longint ceil_v;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_WRITE;
    in_entry_index   = '0;
    in_value         = '0;
    cfg_valid        = 1'b0;
    cfg_table_length = '0;
    quiet            = 1'b0;
    rx_hold_len      = 0;
    settings_made    = 0;
    shortest_len     = int'(LongestLen);
    longest_len      = 0;
    random_items     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // The length is zero after reset, so a search finds nothing.
    send_word(OP_WRITE, IndexW'(0), MinValue);
    send_word(OP_WRITE, IndexW'(1), -1);
    send_word(OP_WRITE, IndexW'(2), 0);
    send_word(OP_WRITE, IndexW'(3), MaxValue);
    send_word(OP_WRITE, IndexW'(TableDepth - 1), MaxValue);
    search_key(0);

    // Four entries covering both ends of the value range, plus near misses.
    settle();
    write_length(4);
    search_key(MinValue);
    search_key(-1);
    search_key(0);
    search_key(MaxValue);
    search_key(1);
    search_key(-2);

    // A single entry, then a length that hides the largest entry.
    settle();
    write_length(1);
    search_key(MinValue);
    search_key(MaxValue);
    settle();
    write_length(3);
    search_key(MaxValue);

    // An out-of-order entry steers the probes away from a present key.
    send_word(OP_WRITE, IndexW'(1), 5);
    search_key(0);
    send_word(OP_WRITE, IndexW'(1), -1);

    // Fill the whole table in order, then search with a saturating length.
    settle();
    lay_sorted(0, TableDepth, longint'(MinValue), longint'(MaxValue));
    settle();
    write_length(LongestLen);
    search_key(sb.table_mirror[TableDepth - 1]);
    search_key(sb.table_mirror[0]);
    search_key(sb.table_mirror[TableDepth / 2]);

    // Random phases, each with its own length and mostly keys from the table.
    phase = 0;
    while (random_items < 200) begin
      settle();
      case (phase % 8)
        0: len = TableLenW'(TableDepth);
        1: len = TableLenW'($urandom_range(1, 16));
        2: len = LongestLen;
        3: len = TableLenW'($urandom_range(TableDepth + 1, int'(LongestLen) - 1));
        4: len = '0;
        5: len = TableLenW'($urandom_range(17, TableDepth - 1));
        6: len = TableLenW'($urandom_range(1, 3));
        default: len = TableLenW'($urandom_range(1, 64));
      endcase
      quiet = (phase % 5 == 2);
      write_length(len);
      span = (int'(len) > TableDepth) ? TableDepth : int'(len);

      // Now and then lay a fresh ordered prefix that still fits below the
      // entries that follow it, sometimes densely packed.
      if (span > 0 && span < 64 && $urandom_range(0, 1) == 1) begin
        floor_v = sb.table_mirror[0];
        ceil_v  = sb.table_mirror[span];
        if ($urandom_range(0, 1) == 1 && floor_v + 2 * span < ceil_v)
          ceil_v = floor_v + 2 * span;
        if (ceil_v >= floor_v) lay_sorted(0, span, floor_v, ceil_v);
      end

      // Once, the result side holds off long enough for the block to back up.
      if (phase == 5) begin
        quiet       = 1'b1;
        rx_hold_len = 400;
      end

      burst = $urandom_range(16, 32);
      for (n = 0; n < burst; n++) begin
        if (phase % 8 == 3 && n == burst / 2) settle();
        pick = $urandom_range(0, 99);
        idx  = (span > 0) ? $urandom_range(0, span - 1) : 0;
        if (pick < 4) begin
          send_word(OP_WRITE, IndexW'($urandom), ValueW'($urandom));
        end else if (span == 0 || pick >= 88) begin
          case ($urandom_range(0, 3))
            0: search_key(MinValue);
            1: search_key(MaxValue);
            default: search_key(ValueW'($urandom));
          endcase
        end else if (pick < 62) begin
          search_key(sb.table_mirror[idx]);
        end else begin
          search_key(sb.table_mirror[idx] + ($urandom_range(0, 1) == 1 ? 1 : -1));
        end
        random_items++;
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d searches (%0d hits) and %0d table writes.",
             sb.searches, sb.hits, sb.writes);
    $display("Used %0d length settings between %0d and %0d, with random and long stalls.",
             settings_made, shortest_len, longest_len);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bsst_pkg.sv
src/bsst_datapath.sv
src/bsst_ctrl.sv
src/binary_search_sorted_table_unit.sv
dv/bsst_tb_pkg.sv
dv/tb_binary_search_sorted_table_unit.sv
